// ----- rtl/core/mm64_pkg.sv -----
`timescale 1ns / 1ps

package mm64_pkg;

    // Control handed from the sequencer to each serial datapath unit
    typedef struct packed {
        logic load;  // take fresh operands, clear the accumulator
        logic step;  // advance one bit
    } t_unit_ctl;

endpackage

// ----- rtl/core/mm64_reduce.sv -----
`timescale 1ns / 1ps

module mm64_reduce
    import mm64_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  t_unit_ctl        i_ctl,
    input  logic [WIDTH-1:0] i_value,
    input  logic [WIDTH-1:0] i_modulus,
    output logic [WIDTH-1:0] o_rem
);

    logic [WIDTH-1:0] r_val;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic [WIDTH-1:0] n_rem;

    // Bring down the next dividend bit, subtract the modulus where it fits
    always_comb begin
        w_trial = {r_rem, r_val[WIDTH-1]};
        w_diff  = w_trial - {1'b0, i_modulus};
        if (w_trial >= {1'b0, i_modulus}) begin
            n_rem = w_diff[WIDTH-1:0];
        end else begin
            n_rem = w_trial[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (i_ctl.step) begin
            r_val <= {r_val[WIDTH-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

// ----- rtl/core/mm64_mac.sv -----
`timescale 1ns / 1ps

module mm64_mac
    import mm64_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  t_unit_ctl        i_ctl,
    input  logic             i_bit,
    input  logic [WIDTH-1:0] i_seed,
    input  logic [WIDTH-1:0] i_modulus,
    output logic [WIDTH-1:0] o_sum
);

    logic [WIDTH-1:0] r_dbl;
    logic [WIDTH-1:0] r_sum;
    logic [WIDTH:0]   w_add;
    logic [WIDTH:0]   w_add_sub;
    logic [WIDTH:0]   w_twice;
    logic [WIDTH:0]   w_twice_sub;
    logic [WIDTH-1:0] n_sum;
    logic [WIDTH-1:0] n_dbl;

    // Both operands stay below the modulus, so one conditional subtract suffices
    always_comb begin
        w_add       = {1'b0, r_sum} + {1'b0, r_dbl};
        w_add_sub   = w_add - {1'b0, i_modulus};
        w_twice     = {r_dbl, 1'b0};
        w_twice_sub = w_twice - {1'b0, i_modulus};
        if (w_add >= {1'b0, i_modulus}) begin
            n_sum = w_add_sub[WIDTH-1:0];
        end else begin
            n_sum = w_add[WIDTH-1:0];
        end
        if (w_twice >= {1'b0, i_modulus}) begin
            n_dbl = w_twice_sub[WIDTH-1:0];
        end else begin
            n_dbl = w_twice[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_dbl <= i_seed;
            r_sum <= '0;
        end else if (i_ctl.step) begin
            r_dbl <= n_dbl;
            if (i_bit) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/core/modular_multiply_64_top.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// request   in         start & !busy       i_multiplicand, i_multiplier, i_modulus
// result    out        o_valid (1 cycle)   o_product_mod
//
// A request runs from acceptance through bit-serial restoring reduction of the
// multiplier, a seed step that loads the double-and-add unit, double-and-add steps
// over the multiplicand bits, LSB first, registration of the result, and the
// strobe. A zero modulus or operand skips the loops and goes straight to
// registering a zero result and the strobe.
// Reset is synchronous, active low, and clears the sequencer and the strobe.
// The receiver cannot stall: o_valid is high for exactly one cycle, and the
// next request may be taken in that same cycle.
module modular_multiply_64_top
    import mm64_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_multiplicand,
    input  logic [WIDTH-1:0] i_multiplier,
    input  logic [WIDTH-1:0] i_modulus,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_product_mod
);

    localparam int CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_SEED   = 5'b00100,
        S_MULT   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [CntW-1:0]   r_cnt;
    logic [CntW-1:0]   n_cnt;
    logic [WIDTH-1:0]  r_mcand;
    logic [WIDTH-1:0]  r_mod;
    logic              r_zero;
    logic              r_valid;
    logic [WIDTH-1:0]  r_prod;
    logic              w_accept;
    logic              w_zero_in;
    t_unit_ctl         w_red_ctl;
    t_unit_ctl         w_mac_ctl;
    logic [WIDTH-1:0]  w_rem;
    logic [WIDTH-1:0]  w_sum;

    assign busy      = (r_state != S_IDLE);
    assign w_accept  = start && !busy;
    // Any zero operand gives zero; a zero modulus would otherwise upset the loops
    assign w_zero_in = (i_modulus == '0) || (i_multiplicand == '0) || (i_multiplier == '0);

    // Sequencer: reduce, seed, double-and-add, deliver
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        w_red_ctl     = '0;
        w_mac_ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_red_ctl.load = 1'b1;
                    n_cnt          = CntW'(WIDTH - 1);
                    n_state        = w_zero_in ? S_DONE : S_REDUCE;
                end
            end
            S_REDUCE: begin
                w_red_ctl.step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                // Remainder is final now: hand it to the double-and-add unit
                w_mac_ctl.load = 1'b1;
                n_cnt          = CntW'(WIDTH - 1);
                n_state        = S_MULT;
            end
            S_MULT: begin
                w_mac_ctl.step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= (r_state == S_DONE);
        end
    end

    // Operand holding: latch on acceptance, shift multiplicand out LSB first; register the result in S_DONE
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mcand <= i_multiplicand;
            r_mod   <= i_modulus;
            r_zero  <= w_zero_in;
        end else if (w_mac_ctl.step) begin
            r_mcand <= {1'b0, r_mcand[WIDTH-1:1]};
        end
        if (r_state == S_DONE) begin
            r_prod <= r_zero ? '0 : w_sum;
        end
    end

    mm64_reduce #(
        .WIDTH (WIDTH)
    ) u_reduce (
        .i_clk     (i_clk),
        .i_ctl     (w_red_ctl),
        .i_value   (i_multiplier),
        .i_modulus (r_mod),
        .o_rem     (w_rem)
    );

    mm64_mac #(
        .WIDTH (WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_ctl     (w_mac_ctl),
        .i_bit     (r_mcand[0]),
        .i_seed    (w_rem),
        .i_modulus (r_mod),
        .o_sum     (w_sum)
    );

    assign o_valid       = r_valid;
    assign o_product_mod = r_prod;

endmodule
